@@ rtl/core/dsky_pkg.sv @@
// dsky_pkg: shared types, row codes and the segment code table for the
// display relay word decoder. No dependencies.
`timescale 1ns / 1ps

package dsky_pkg;

    localparam int unsigned WORD_W  = 15;
    localparam int unsigned CODE_W  = 5;
    localparam int unsigned ROW_W   = 4;
    localparam int unsigned DIGIT_W = 4;

    typedef logic [DIGIT_W-1:0]   digit_t;
    typedef logic [2*DIGIT_W-1:0] pair_t;
    typedef logic [5*DIGIT_W-1:0] reg_digits_t;
    typedef logic [ROW_W-1:0]     row_t;
    typedef logic [CODE_W-1:0]    seg_code_t;
    typedef logic [3:0]           lights_t;

    localparam digit_t        BLANK_DIGIT = 4'd15;
    localparam pair_t         BLANK_PAIR  = 8'hFF;
    localparam reg_digits_t   BLANK_REG   = 20'hFFFFF;

    typedef enum logic [1:0] {
        SIGN_BLANK = 2'd0,
        SIGN_PLUS  = 2'd1,
        SIGN_MINUS = 2'd2
    } sign_t;

    // Relay row select codes
    localparam row_t ROW_LIGHTS = 4'd12;
    localparam row_t ROW_PROG   = 4'd11;
    localparam row_t ROW_VERB   = 4'd10;
    localparam row_t ROW_NOUN   = 4'd9;
    localparam row_t ROW_R1_D1  = 4'd8;
    localparam row_t ROW_R1_D23 = 4'd7;
    localparam row_t ROW_R1_D45 = 4'd6;
    localparam row_t ROW_R2_D12 = 4'd5;
    localparam row_t ROW_R2_D34 = 4'd4;
    localparam row_t ROW_R2R3   = 4'd3;
    localparam row_t ROW_R3_D23 = 4'd2;
    localparam row_t ROW_R3_D45 = 4'd1;

    // Decoded relay word
    typedef struct packed {
        row_t    row;
        logic    sign_on;
        digit_t  left;
        digit_t  right;
        lights_t lights;
    } relay_cmd_t;

    // Whole display contents
    typedef struct packed {
        pair_t       prog;
        pair_t       verb;
        pair_t       noun;
        reg_digits_t reg1;
        sign_t       reg1_sign;
        reg_digits_t reg2;
        sign_t       reg2_sign;
        reg_digits_t reg3;
        sign_t       reg3_sign;
        lights_t     lights;
    } display_t;

    // Seven-segment relay code to decimal digit; unknown codes show blank
    function automatic digit_t seg_to_digit(input seg_code_t code);
        digit_t d;
        unique case (code)
            5'd21:   d = 4'd0;
            5'd3:    d = 4'd1;
            5'd25:   d = 4'd2;
            5'd27:   d = 4'd3;
            5'd15:   d = 4'd4;
            5'd30:   d = 4'd5;
            5'd28:   d = 4'd6;
            5'd19:   d = 4'd7;
            5'd29:   d = 4'd8;
            5'd31:   d = 4'd9;
            default: d = BLANK_DIGIT;
        endcase
        return d;
    endfunction

endpackage

@@ rtl/core/dsky_relay_word_decoder.sv @@
// dsky_relay_word_decoder: top level. Input register, word decode and the
// display stores, which double as the result register.
// Depends on dsky_pkg, dsky_word_decode, dsky_display_regs.
//
//   channel | signals                         | payload
//   --------+---------------------------------+------------------------------
//   in      | in_valid / in_ready             | relay_word
//   out     | out_valid / out_ready           | prog/verb/noun_digits,
//           |                                 | reg1..3_digits, reg1..3_sign,
//           |                                 | warning_lights
//
// One request per cycle sustained while out_ready is high; an accepted
// request passes through the input register, then the display stores,
// before out_valid rises.
// The display stores are the result: they only change when the held
// request moves forward, so a stalled result stays put.
// A stalled output backs up into the input register, then drops in_ready.
// Reset blanks all digits and signs and clears the lights.
`timescale 1ns / 1ps

module dsky_relay_word_decoder
    import dsky_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  logic [WORD_W-1:0]   relay_word,
    output logic                out_valid,
    input  logic                out_ready,
    output logic [7:0]          prog_digits,
    output logic [7:0]          verb_digits,
    output logic [7:0]          noun_digits,
    output logic [19:0]         reg1_digits,
    output logic [1:0]          reg1_sign,
    output logic [19:0]         reg2_digits,
    output logic [1:0]          reg2_sign,
    output logic [19:0]         reg3_digits,
    output logic [1:0]          reg3_sign,
    output logic [3:0]          warning_lights
);

    logic [WORD_W-1:0] word_reg;
    logic              hold_valid_reg;
    logic              hold_valid_next;
    logic              out_valid_reg;
    logic              out_valid_next;
    logic              advance;
    relay_cmd_t        cmd;
    display_t          disp;

    // Handshake: held request moves on when the result slot is free or its result is taken
    assign advance  = hold_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready = !hold_valid_reg || advance;

    always_comb
    begin
        hold_valid_next = hold_valid_reg;
        if (in_valid && in_ready)
            hold_valid_next = 1'b1;
        else if (advance)
            hold_valid_next = 1'b0;

        out_valid_next = out_valid_reg;
        if (advance)
            out_valid_next = 1'b1;
        else if (out_ready)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hold_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            hold_valid_reg <= hold_valid_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    // Input word register
    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
            word_reg <= relay_word;
    end

    dsky_word_decode u_decode (
        .relay_word (word_reg),
        .cmd        (cmd)
    );

    dsky_display_regs u_display (
        .clk   (clk),
        .rst_n (rst_n),
        .load  (advance),
        .cmd   (cmd),
        .disp  (disp)
    );

    // Result ports
    assign out_valid      = out_valid_reg;
    assign prog_digits    = disp.prog;
    assign verb_digits    = disp.verb;
    assign noun_digits    = disp.noun;
    assign reg1_digits    = disp.reg1;
    assign reg1_sign      = disp.reg1_sign;
    assign reg2_digits    = disp.reg2;
    assign reg2_sign      = disp.reg2_sign;
    assign reg3_digits    = disp.reg3;
    assign reg3_sign      = disp.reg3_sign;
    assign warning_lights = disp.lights;

endmodule

@@ rtl/core/dsky_word_decode.sv @@
// dsky_word_decode: splits a relay word into row, sign bit, two decoded
// digits and the light bits. Depends on dsky_pkg.
`timescale 1ns / 1ps

module dsky_word_decode
    import dsky_pkg::*;
(
    input  logic [WORD_W-1:0] relay_word,
    output relay_cmd_t        cmd
);

    // Field split and segment decode
    always_comb
    begin
        cmd.row     = relay_word[14:11];
        cmd.sign_on = relay_word[10];
        cmd.left    = seg_to_digit(relay_word[9:5]);
        cmd.right   = seg_to_digit(relay_word[4:0]);
        // lights come from raw word bits 3, 5, 7, 8
        cmd.lights  = {relay_word[8], relay_word[7], relay_word[5], relay_word[3]};
    end

endmodule

@@ rtl/core/dsky_display_regs.sv @@
// dsky_display_regs: the display stores, updated by one decoded relay
// request when load is high. Depends on dsky_pkg.
`timescale 1ns / 1ps

module dsky_display_regs
    import dsky_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       load,
    input  relay_cmd_t cmd,
    output display_t   disp
);

    display_t disp_reg;
    display_t disp_next;

    // Set sign to this row's kind, or blank it only if it shows that kind
    function automatic sign_t sign_update(input sign_t cur, input sign_t kind, input logic on);
        sign_t s;
        if (on)
            s = kind;
        else if (cur == kind)
            s = SIGN_BLANK;
        else
            s = cur;
        return s;
    endfunction

    // Row-addressed update of the stores
    always_comb
    begin
        disp_next = disp_reg;
        unique case (cmd.row)
            ROW_PROG:   disp_next.prog = {cmd.left, cmd.right};
            ROW_VERB:   disp_next.verb = {cmd.left, cmd.right};
            ROW_NOUN:   disp_next.noun = {cmd.left, cmd.right};
            ROW_R1_D1:  disp_next.reg1[19:16] = cmd.right;
            ROW_R1_D23:
            begin
                disp_next.reg1[15:8]  = {cmd.left, cmd.right};
                disp_next.reg1_sign   = sign_update(disp_reg.reg1_sign, SIGN_PLUS, cmd.sign_on);
            end
            ROW_R1_D45:
            begin
                disp_next.reg1[7:0]   = {cmd.left, cmd.right};
                disp_next.reg1_sign   = sign_update(disp_reg.reg1_sign, SIGN_MINUS, cmd.sign_on);
            end
            ROW_R2_D12:
            begin
                disp_next.reg2[19:12] = {cmd.left, cmd.right};
                disp_next.reg2_sign   = sign_update(disp_reg.reg2_sign, SIGN_PLUS, cmd.sign_on);
            end
            ROW_R2_D34:
            begin
                disp_next.reg2[11:4]  = {cmd.left, cmd.right};
                disp_next.reg2_sign   = sign_update(disp_reg.reg2_sign, SIGN_MINUS, cmd.sign_on);
            end
            ROW_R2R3:
            begin
                disp_next.reg2[3:0]   = cmd.left;
                disp_next.reg3[19:16] = cmd.right;
            end
            ROW_R3_D23:
            begin
                disp_next.reg3[15:8]  = {cmd.left, cmd.right};
                disp_next.reg3_sign   = sign_update(disp_reg.reg3_sign, SIGN_PLUS, cmd.sign_on);
            end
            ROW_R3_D45:
            begin
                disp_next.reg3[7:0]   = {cmd.left, cmd.right};
                disp_next.reg3_sign   = sign_update(disp_reg.reg3_sign, SIGN_MINUS, cmd.sign_on);
            end
            ROW_LIGHTS: disp_next.lights = cmd.lights;
            default:    ; // unused rows leave the display alone
        endcase
    end

    // Display stores
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            disp_reg.prog      <= BLANK_PAIR;
            disp_reg.verb      <= BLANK_PAIR;
            disp_reg.noun      <= BLANK_PAIR;
            disp_reg.reg1      <= BLANK_REG;
            disp_reg.reg1_sign <= SIGN_BLANK;
            disp_reg.reg2      <= BLANK_REG;
            disp_reg.reg2_sign <= SIGN_BLANK;
            disp_reg.reg3      <= BLANK_REG;
            disp_reg.reg3_sign <= SIGN_BLANK;
            disp_reg.lights    <= '0;
        end
        else if (load)
        begin
            disp_reg <= disp_next;
        end
    end

    assign disp = disp_reg;

endmodule

@@ rtl/core/dsky_checker.sv @@
// dsky_checker: port-level assertions for the relay word decoder, bound
// to the top level. Depends on dsky_relay_word_decoder ports only.
`timescale 1ns / 1ps

module dsky_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        in_valid,
    input logic        in_ready,
    input logic        out_valid,
    input logic        out_ready,
    input logic [7:0]  prog_digits,
    input logic [1:0]  reg1_sign,
    input logic [19:0] reg1_digits,
    input logic [3:0]  warning_lights
);

    // Empty result slot means the input side can never be blocked
    a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid |-> in_ready)
        else $error("in_ready low with no pending result");

    // An accepted request reaches the output when nothing is in the way
    a_request_delivered: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) ##1 !out_valid |=> out_valid)
        else $error("accepted request did not produce a result");

    // Program digits are decimal or blank
    a_prog_digit_range: assert property (@(posedge clk) disable iff (!rst_n)
        (prog_digits[7:4] <= 4'd9 || prog_digits[7:4] == 4'd15) &&
        (prog_digits[3:0] <= 4'd9 || prog_digits[3:0] == 4'd15))
        else $error("prog digit outside decimal or blank");

    // Stalled result holds: out_valid, reg1 digits and sign, and the lights
    a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(reg1_digits) &&
        $stable(reg1_sign) && $stable(warning_lights))
        else $error("result changed while stalled");

endmodule

bind dsky_relay_word_decoder dsky_checker u_dsky_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .prog_digits    (prog_digits),
    .reg1_sign      (reg1_sign),
    .reg1_digits    (reg1_digits),
    .warning_lights (warning_lights)
);
